>>> rtl/scfl_pkg.sv
// ----------------------------------------------------------------------------
// scfl_pkg
// Shared constants, codes and port structs for the size-class free-list
// allocator and its link memory.
// ----------------------------------------------------------------------------
package scfl_pkg;

  // Heap and class geometry.
  localparam int unsigned HEAP_LIMIT  = 65536;
  localparam int unsigned NODE_COUNT  = 20;
  localparam int unsigned CLASS_COUNT = 16;
  localparam int unsigned MAX_SMALL   = 128;
  localparam int unsigned GRAN_BYTES  = 8;
  localparam int unsigned GRAN_SHIFT  = 3;
  localparam int unsigned GRANULES    = HEAP_LIMIT / GRAN_BYTES;

  // Widths derived from the geometry.
  localparam int unsigned GIDX_W  = $clog2(GRANULES);
  localparam int unsigned LINK_W  = GIDX_W + 1;
  localparam int unsigned CLS_W   = $clog2(CLASS_COUNT);
  localparam int unsigned BYTE_W  = $clog2(HEAP_LIMIT) + 1;
  localparam int unsigned RS_W    = $clog2(MAX_SMALL) + 1;
  localparam int unsigned CNT_W   = $clog2(NODE_COUNT);
  localparam int unsigned CHUNK_MULT = NODE_COUNT * 2;

  // Operation codes.
  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_OOM   = 2'd2;

  // Link memory write and read requests.
  typedef struct packed {
    logic              en;
    logic [GIDX_W-1:0] addr;
    logic [LINK_W-1:0] data;
  } link_wr_t;

  typedef struct packed {
    logic              en;
    logic [GIDX_W-1:0] addr;
  } link_rd_t;

endpackage

>>> rtl/size_class_free_list_allocator_unit.sv
// ----------------------------------------------------------------------------
// size_class_free_list_allocator_unit
// Segregated free-list allocator: 16 size classes in 8-byte steps, list
// heads in flip-flops, next links in a granule-indexed memory, a carve
// window and a bump pointer into a 64 KiB heap.
// ----------------------------------------------------------------------------
// One item is processed at a time; a new item is taken once the previous
// result has moved to the output register.
// A refill pushes any remnant, cuts a chunk if needed, then makes one
// link-memory write per carved block, at most 20.
// Reset is synchronous: list heads, window and heap pointers clear at once;
// the link memory is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module size_class_free_list_allocator_unit
  import scfl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_op,
  input  logic [15:0] in_request_size,
  input  logic [15:0] in_block_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_granted_address,
  output logic [1:0]  out_status
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_REFILL,
    S_CHUNK,
    S_CARVE,
    S_POP,
    S_POP_WAIT,
    S_DONE
  } state_t;

  localparam logic [BYTE_W-1:0] LIMIT_B   = BYTE_W'(HEAP_LIMIT);
  localparam logic [BYTE_W-1:0] MULT_B    = BYTE_W'(CHUNK_MULT);
  localparam logic [BYTE_W-1:0] ROUND_B   = BYTE_W'(GRAN_BYTES - 1);
  localparam logic [BYTE_W-1:0] GMASK_B   = ~ROUND_B;
  localparam logic [CNT_W-1:0]  CNT_LAST  = CNT_W'(NODE_COUNT - 1);
  localparam logic [RS_W-1:0]   RS_MASK   = ~RS_W'(GRAN_BYTES - 1);

  state_t            state_r, state_nxt;
  logic              op_r, op_nxt;
  logic [RS_W-1:0]   rs_r, rs_nxt;
  logic [CLS_W-1:0]  cls_r, cls_nxt;
  logic [GIDX_W-1:0] rel_g_r, rel_g_nxt;
  logic [LINK_W-1:0] head_r [CLASS_COUNT];
  logic [LINK_W-1:0] head_nxt [CLASS_COUNT];
  logic [BYTE_W-1:0] win_start_r, win_start_nxt;
  logic [BYTE_W-1:0] win_end_r, win_end_nxt;
  logic [BYTE_W-1:0] heap_top_r, heap_top_nxt;
  logic [BYTE_W-1:0] total_r, total_nxt;
  logic [BYTE_W-1:0] carve_addr_r, carve_addr_nxt;
  logic [CNT_W-1:0]  carve_cnt_r, carve_cnt_nxt;
  logic [15:0]       res_addr_r, res_addr_nxt;
  logic [1:0]        res_status_r, res_status_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [15:0]       out_addr_r, out_addr_nxt;
  logic [1:0]        out_status_r, out_status_nxt;

  link_wr_t          link_wr;
  link_rd_t          link_rd;
  logic [LINK_W-1:0] link_rdata;

  // Decode of the incoming size.
  logic [RS_W-1:0]   in_rs;
  logic [CLS_W-1:0]  in_cls;
  logic              in_range_err;

  // Refill arithmetic.
  logic [LINK_W-1:0] cur_head;
  logic [BYTE_W-1:0] rs_b;
  logic [BYTE_W-1:0] freeb;
  logic [CLS_W-1:0]  rem_cls;
  logic [BYTE_W-1:0] chunk_rnd;
  logic [BYTE_W-1:0] heap_left;
  logic [BYTE_W-1:0] chunk_cut;
  logic [GIDX_W-1:0] carve_g;
  logic              carve_last;
  logic [GIDX_W-1:0] win_g;

  scfl_link_ram u_link_ram (
    .clk     (clk),
    .wr      (link_wr),
    .rd      (link_rd),
    .rd_data (link_rdata)
  );

  // Size rounding and class decode.
  always_comb begin
    in_rs        = RS_W'(in_request_size[RS_W-1:0] + RS_W'(GRAN_BYTES - 1)) & RS_MASK;
    in_cls       = CLS_W'((in_rs >> GRAN_SHIFT) - RS_W'(1));
    in_range_err = (in_request_size == 16'd0) || (in_request_size > 16'(MAX_SMALL));
  end

  // Datapath terms shared by the sequencer states.
  always_comb begin
    cur_head   = head_r[cls_r];
    rs_b       = BYTE_W'(rs_r);
    freeb      = win_end_r - win_start_r;
    rem_cls    = CLS_W'(freeb[BYTE_W-1:GRAN_SHIFT] - (BYTE_W - GRAN_SHIFT)'(1));
    chunk_rnd  = (rs_b * MULT_B + (total_r >> 4) + ROUND_B) & GMASK_B;
    heap_left  = LIMIT_B - heap_top_r;
    chunk_cut  = (chunk_rnd > heap_left) ? (heap_left & GMASK_B) : chunk_rnd;
    carve_g    = carve_addr_r[GIDX_W+GRAN_SHIFT-1:GRAN_SHIFT];
    carve_last = (carve_cnt_r == CNT_LAST) ||
                 ((carve_addr_r + (rs_b << 1)) > win_end_r);
    win_g      = win_start_r[GIDX_W+GRAN_SHIFT-1:GRAN_SHIFT];
  end

  // Sequencer next-state and datapath.
  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    rs_nxt         = rs_r;
    cls_nxt        = cls_r;
    rel_g_nxt      = rel_g_r;
    head_nxt       = head_r;
    win_start_nxt  = win_start_r;
    win_end_nxt    = win_end_r;
    heap_top_nxt   = heap_top_r;
    total_nxt      = total_r;
    carve_addr_nxt = carve_addr_r;
    carve_cnt_nxt  = carve_cnt_r;
    res_addr_nxt   = res_addr_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r;
    out_addr_nxt   = out_addr_r;
    out_status_nxt = out_status_r;
    link_wr        = '0;
    link_rd        = '0;

    // The output register empties when the result side takes the item.
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt         = in_op;
          rs_nxt         = in_rs;
          cls_nxt        = in_cls;
          rel_g_nxt      = in_block_address[GIDX_W+GRAN_SHIFT-1:GRAN_SHIFT];
          res_addr_nxt   = 16'd0;
          res_status_nxt = ST_OK;
          if (in_range_err) begin
            res_status_nxt = ST_RANGE;
            state_nxt      = S_DONE;
          end else begin
            state_nxt = S_START;
          end
        end
      end

      S_START: begin
        if (op_r == OP_RELEASE) begin
          // Push the released block onto the head of its class list.
          link_wr.en     = 1'b1;
          link_wr.addr   = rel_g_r;
          link_wr.data   = cur_head;
          head_nxt[cls_r] = LINK_W'(rel_g_r) + LINK_W'(1);
          state_nxt      = S_DONE;
        end else if (cur_head != '0) begin
          state_nxt = S_POP;
        end else begin
          state_nxt = S_REFILL;
        end
      end

      S_REFILL: begin
        if (freeb != '0 && freeb < rs_b) begin
          // Remnant too small for this class goes onto its own list.
          link_wr.en        = 1'b1;
          link_wr.addr      = win_g;
          link_wr.data      = head_r[rem_cls];
          head_nxt[rem_cls] = LINK_W'(win_g) + LINK_W'(1);
          win_start_nxt     = win_end_r;
          state_nxt         = S_CHUNK;
        end else if (freeb == '0) begin
          state_nxt = S_CHUNK;
        end else begin
          carve_addr_nxt = win_start_r;
          carve_cnt_nxt  = '0;
          state_nxt      = S_CARVE;
        end
      end

      S_CHUNK: begin
        // Cut a new chunk from the heap, trimmed to what is left.
        if (chunk_cut < rs_b) begin
          res_status_nxt = ST_OOM;
          state_nxt      = S_DONE;
        end else begin
          win_start_nxt  = heap_top_r;
          win_end_nxt    = heap_top_r + chunk_cut;
          heap_top_nxt   = heap_top_r + chunk_cut;
          total_nxt      = total_r + chunk_cut;
          carve_addr_nxt = heap_top_r;
          carve_cnt_nxt  = '0;
          state_nxt      = S_CARVE;
        end
      end

      S_CARVE: begin
        // Link one block a cycle; each points at the next, the last at null.
        link_wr.en   = 1'b1;
        link_wr.addr = carve_g;
        link_wr.data = carve_last ? '0 :
                       LINK_W'(carve_g) + LINK_W'(rs_r >> GRAN_SHIFT) + LINK_W'(1);
        if (carve_cnt_r == '0) begin
          head_nxt[cls_r] = LINK_W'(carve_g) + LINK_W'(1);
        end
        carve_addr_nxt = carve_addr_r + rs_b;
        carve_cnt_nxt  = carve_cnt_r + CNT_W'(1);
        if (carve_last) begin
          win_start_nxt = carve_addr_r + rs_b;
          state_nxt     = S_POP;
        end
      end

      S_POP: begin
        link_rd.en   = 1'b1;
        link_rd.addr = GIDX_W'(cur_head - LINK_W'(1));
        state_nxt    = S_POP_WAIT;
      end

      S_POP_WAIT: begin
        head_nxt[cls_r] = link_rdata;
        res_addr_nxt    = 16'({GIDX_W'(cur_head - LINK_W'(1)), GRAN_SHIFT'(0)});
        state_nxt       = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_addr_nxt   = res_addr_r;
          out_status_nxt = res_status_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State, list heads, window and output registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      win_start_r <= '0;
      win_end_r   <= '0;
      heap_top_r  <= '0;
      total_r     <= '0;
      for (int i = 0; i < CLASS_COUNT; i++) begin
        head_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      win_start_r <= win_start_nxt;
      win_end_r   <= win_end_nxt;
      heap_top_r  <= heap_top_nxt;
      total_r     <= total_nxt;
      head_r      <= head_nxt;
    end
    op_r         <= op_nxt;
    rs_r         <= rs_nxt;
    cls_r        <= cls_nxt;
    rel_g_r      <= rel_g_nxt;
    carve_addr_r <= carve_addr_nxt;
    carve_cnt_r  <= carve_cnt_nxt;
    res_addr_r   <= res_addr_nxt;
    res_status_r <= res_status_nxt;
    out_addr_r   <= out_addr_nxt;
    out_status_r <= out_status_nxt;
  end

  // Ports.
  assign in_stall            = (state_r != S_IDLE);
  assign out_valid           = out_valid_r;
  assign out_granted_address = out_addr_r;
  assign out_status          = out_status_r;

  // The carve window always lies below the bump pointer.
  ap_window_order: assert property (@(posedge clk) disable iff (!rst_n)
    (win_start_r <= win_end_r) && (win_end_r <= heap_top_r))
    else $error("carve window out of order");

  // The bump pointer never passes the end of the heap.
  ap_heap_bound: assert property (@(posedge clk) disable iff (!rst_n)
    heap_top_r <= LIMIT_B)
    else $error("heap pointer beyond heap limit");

  // A refill never links more than the node count.
  ap_carve_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CARVE) |-> (carve_cnt_r <= CNT_LAST))
    else $error("carve count overrun");

  // Any error result carries a zero address.
  ap_error_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != ST_OK)) |-> (out_addr_r == 16'd0))
    else $error("error result with nonzero address");

  // A carve step follows only a refill, a chunk cut or another carve step.
  ap_carve_entry: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r == S_CARVE) |->
      ($past(state_r) == S_REFILL || $past(state_r) == S_CHUNK))
    else $error("carve entered from wrong state");

endmodule

>>> rtl/scfl_link_ram.sv
// ----------------------------------------------------------------------------
// scfl_link_ram
// Next-link memory, one entry per heap granule. One write port and one
// read port; read data is registered. No reset.
// ----------------------------------------------------------------------------
module scfl_link_ram
  import scfl_pkg::*;
(
  input  logic              clk,
  input  link_wr_t          wr,
  input  link_rd_t          rd,
  output logic [LINK_W-1:0] rd_data
);

  logic [LINK_W-1:0] mem [GRANULES];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data <= mem[rd.addr];
    end
  end

endmodule

>>> bench/size_class_free_list_allocator_unit_tb.sv
// ----------------------------------------------------------------------------
// size_class_free_list_allocator_unit_tb
// Self-checking bench for the size-class free-list allocator. A queue of
// pending items feeds a clocked driver, and a clocked monitor stalls the
// result side at random. Each accepted item runs through a local allocator
// model: class heads, next links, carve window and heap bump pointer. The
// monitor compares every result with the oldest predicted one. Released
// blocks are mostly real grants, so the lists recycle and the heap runs dry.
// ----------------------------------------------------------------------------
module size_class_free_list_allocator_unit_tb;
  import scfl_pkg::*;

  typedef struct {
    logic        op;
    logic [15:0] size;
    logic [15:0] addr;
  } request_t;

  typedef struct {
    logic [15:0] granted;
    logic [1:0]  status;
  } grant_t;

  typedef struct {
    logic [15:0] addr;
    logic [15:0] size;
  } held_block_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_op = OP_ALLOC;
  logic [15:0] in_request_size = 16'h0000;
  logic [15:0] in_block_address = 16'h0000;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] out_granted_address;
  logic [1:0]  out_status;

  // Stimulus and scoreboard storage.
  request_t    pending_requests [$];
  grant_t      grants_due [$];
  held_block_t held_blocks [$];
  request_t    offered_req;
  grant_t      predicted;
  grant_t      due;
  int unsigned mismatch_count = 0;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  int unsigned hold_requests = 0;
  int unsigned holds_served = 0;
  bit          send_idle_on = 1'b1;
  bit          recv_idle_on = 1'b1;

  // Allocator state mirrored by the predictor.
  logic [LINK_W-1:0] class_head [CLASS_COUNT];
  logic [LINK_W-1:0] next_link [GRANULES];
  int unsigned       win_start = 0;
  int unsigned       win_end = 0;
  int unsigned       heap_top = 0;
  int unsigned       bytes_taken = 0;

  size_class_free_list_allocator_unit dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_op               (in_op),
    .in_request_size     (in_request_size),
    .in_block_address    (in_block_address),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_granted_address (out_granted_address),
    .out_status          (out_status)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Pushes a block onto the head of its class list.
  function automatic void push_free(int unsigned cls, int unsigned addr);
    int unsigned g;
    g = (addr >> GRAN_SHIFT) & (GRANULES - 1);
    if (cls >= CLASS_COUNT) return;
    next_link[g] = class_head[cls];
    class_head[cls] = LINK_W'(g + 1);
  endfunction

  // Fills an empty class list from the window, cutting a new chunk if needed.
  function automatic bit refill_class(int unsigned cls, int unsigned rs);
    int unsigned free_bytes;
    int unsigned chunk;
    int unsigned left;
    int unsigned n;
    free_bytes = win_end - win_start;
    if (free_bytes != 0 && free_bytes < rs) begin
      // A leftover too small for this class becomes one block of its own class.
      push_free((free_bytes >> 3) - 1, win_start);
      win_start = win_end;
      free_bytes = 0;
    end
    if (free_bytes == 0) begin
      chunk = rs * NODE_COUNT * 2 + (bytes_taken >> 4);
      left = (HEAP_LIMIT > heap_top) ? HEAP_LIMIT - heap_top : 0;
      chunk = (chunk + 7) & ~32'd7;
      if (chunk > left) chunk = left & ~32'd7;
      if (chunk < rs) return 1'b0;
      win_start = heap_top;
      win_end = heap_top + chunk;
      heap_top += chunk;
      bytes_taken = (bytes_taken + chunk) & 32'h1FFFF;
      free_bytes = chunk;
    end
    n = free_bytes / rs;
    if (n > NODE_COUNT) n = NODE_COUNT;
    // Link from the last block to the first so the first ends up at the head.
    for (int unsigned i = n; i > 0; i--) push_free(cls, win_start + (i - 1) * rs);
    win_start += n * rs;
    return 1'b1;
  endfunction

  // Works out the result of one request and updates the allocator state.
  function automatic grant_t predict_grant(request_t req);
    grant_t      res;
    int unsigned size_v;
    int unsigned rs;
    int unsigned cls;
    int unsigned g;
    res.granted = 16'h0000;
    res.status = ST_OK;
    size_v = req.size;
    if (size_v == 0 || size_v > MAX_SMALL) begin
      res.status = ST_RANGE;
      return res;
    end
    rs = (size_v + 7) & ~32'd7;
    cls = (rs >> 3) - 1;
    if (cls >= CLASS_COUNT) begin
      res.status = ST_RANGE;
      return res;
    end
    if (req.op == OP_RELEASE) begin
      push_free(cls, req.addr);
      return res;
    end
    if (class_head[cls] == 0 && !refill_class(cls, rs)) begin
      res.status = ST_OOM;
      return res;
    end
    if (class_head[cls] == 0) begin
      res.status = ST_OOM;
      return res;
    end
    g = (class_head[cls] - 1) & (GRANULES - 1);
    class_head[cls] = next_link[g];
    res.granted = 16'(g << GRAN_SHIFT);
    return res;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap(bit enabled);
    int unsigned r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic push_request(logic op, logic [15:0] size, logic [15:0] addr);
    request_t req;
    req.op = op;
    req.size = size;
    req.addr = addr;
    pending_requests.push_back(req);
  endtask

  // One random item: mostly allocations and releases of granted blocks,
  // with some malformed sizes and foreign releases mixed in.
  task automatic queue_random_request(int unsigned alloc_pct);
    request_t    req;
    int unsigned r;
    int unsigned idx;
    int unsigned rs;
    r = $urandom_range(0, 99);
    req.addr = 16'($urandom());
    req.size = 16'($urandom_range(1, MAX_SMALL));
    if (r < 6) begin
      req.op = 1'($urandom_range(0, 1));
      req.size = ($urandom_range(0, 3) == 0) ? 16'h0000
                                              : 16'($urandom_range(MAX_SMALL + 1, 65535));
    end else if (r < 10) begin
      req.op = OP_RELEASE;
    end else if (r < 10 + alloc_pct * 90 / 100 || held_blocks.size() == 0) begin
      req.op = OP_ALLOC;
      if ($urandom_range(0, 1) == 0) req.size = 16'($urandom_range(1, 24));
    end else begin
      idx = $urandom_range(0, held_blocks.size() - 1);
      rs = (held_blocks[idx].size + 7) & ~32'd7;
      req.op = OP_RELEASE;
      req.addr = held_blocks[idx].addr | 16'($urandom_range(0, 7));
      req.size = 16'(rs - $urandom_range(0, 7));
      held_blocks.delete(idx);
    end
    pending_requests.push_back(req);
  endtask

  // Driver: presents pending items and predicts each one as it is accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predicted = predict_grant(offered_req);
        grants_due.push_back(predicted);
        if (offered_req.op == OP_ALLOC && predicted.status == ST_OK)
          held_blocks.push_back('{predicted.granted, offered_req.size});
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_requests.size() > 0) begin
          offered_req = pending_requests.pop_front();
          in_valid <= 1'b1;
          in_op <= offered_req.op;
          in_request_size <= offered_req.size;
          in_block_address <= offered_req.addr;
          send_gap = pick_gap(send_idle_on);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks accepted results and stalls the result side.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (grants_due.size() == 0) begin
          $display("%0t: result with none expected: granted_address %h status %0d",
                   $time, out_granted_address, out_status);
          mismatch_count++;
        end else begin
          due = grants_due.pop_front();
          if (out_granted_address !== due.granted) begin
            $display("%0t: granted_address expected %h, got %h",
                     $time, due.granted, out_granted_address);
            mismatch_count++;
          end
          if (out_status !== due.status) begin
            $display("%0t: status expected %0d, got %0d", $time, due.status, out_status);
            mismatch_count++;
          end
        end
      end
      // A requested hold keeps the result side blocked for a long stretch.
      if (holds_served < hold_requests) begin
        holds_served++;
        stall_left = 300;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        stall_left = pick_gap(recv_idle_on);
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    int unsigned alloc_pct;
    for (int i = 0; i < CLASS_COUNT; i++) class_head[i] = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Range errors on both operations, at both ends of the size field.
    push_request(OP_ALLOC, 16'd0, 16'h0000);
    push_request(OP_ALLOC, 16'd129, 16'h0000);
    push_request(OP_RELEASE, 16'hFFFF, 16'hFFFF);
    // First chunk, then a class that leaves a remnant too small for the next.
    push_request(OP_ALLOC, 16'd72, 16'hFFFF);
    push_request(OP_ALLOC, 16'd128, 16'h0000);
    push_request(OP_ALLOC, 16'd40, 16'h0000);
    push_request(OP_ALLOC, 16'd32, 16'h0000);
    push_request(OP_ALLOC, 16'd1, 16'h0000);
    push_request(OP_ALLOC, 16'd8, 16'h0000);
    push_request(OP_ALLOC, 16'd9, 16'h0000);
    // Releases ignore the low address bits and come back first.
    push_request(OP_RELEASE, 16'd1, 16'hFFFF);
    push_request(OP_ALLOC, 16'd1, 16'h0000);
    push_request(OP_RELEASE, 16'd128, 16'h0000);
    push_request(OP_ALLOC, 16'd121, 16'h0000);
    push_request(OP_RELEASE, 16'd100, 16'h5557);
    push_request(OP_ALLOC, 16'd97, 16'h0000);
    push_request(OP_RELEASE, 16'd16, 16'hAAAA);
    push_request(OP_ALLOC, 16'd16, 16'hAAAA);

    // Random phases with varying allocation pressure and idling.
    for (int seg = 0; seg < 12; seg++) begin
      @(negedge clk);
      alloc_pct = $urandom_range(25, 90);
      send_idle_on = (seg == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
      recv_idle_on = (seg == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
      if (seg == 5) begin
        send_idle_on = 1'b0;
        hold_requests++;
      end
      for (int k = 0; k < 145; k++) begin
        while (pending_requests.size() >= 3) @(negedge clk);
        queue_random_request(alloc_pct);
      end
    end

    while (pending_requests.size() != 0 || in_valid) @(negedge clk);
    while (grants_due.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
